>>> hw/rtl/i2cmbt_pkg.sv
// ----------------------------------------------------------------------------
// I2C master byte transactions: shared types and constants
// Bus phase codes, operation codes, byte index codes and the per-tick result.
// ----------------------------------------------------------------------------
package i2cmbt_pkg;

  typedef enum logic [13:0] {
    PH_IDLE    = 14'b00000000000001,
    PH_START_A = 14'b00000000000010,
    PH_START_B = 14'b00000000000100,
    PH_WB_LO   = 14'b00000000001000,
    PH_WB_HI   = 14'b00000000010000,
    PH_WA_LO   = 14'b00000000100000,
    PH_WA_HI   = 14'b00000001000000,
    PH_RB_LO   = 14'b00000010000000,
    PH_RB_HI   = 14'b00000100000000,
    PH_MA_LO   = 14'b00001000000000,
    PH_MA_HI   = 14'b00010000000000,
    PH_STOP_A  = 14'b00100000000000,
    PH_STOP_B  = 14'b01000000000000,
    PH_STOP_C  = 14'b10000000000000
  } phase_t;

  localparam logic       OP_WRITE      = 1'b0;
  localparam logic       OP_READ       = 1'b1;

  localparam logic [1:0] BYTE_ADDR     = 2'd0;
  localparam logic [1:0] BYTE_FIRST    = 2'd1;
  localparam logic [1:0] BYTE_SECOND   = 2'd2;

  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  typedef struct packed {
    logic        scl;
    logic        sda_out;
    logic        sda_drive;
    logic        busy_res;
    logic        done_res;
    logic [15:0] read_word;
    logic        addr_nack;
    logic        data_nack;
  } res_t;

endpackage

>>> hw/rtl/i2cmbt_core.sv
// ----------------------------------------------------------------------------
// I2C master byte transactions: bus sequencer
// Phase state machine, bit and byte counters, and per-tick bus levels.
// ----------------------------------------------------------------------------
module i2cmbt_core
  import i2cmbt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] phase_ticks,
  input  logic       cmd_valid,
  input  logic       opcode,
  input  logic [6:0] slave_addr,
  input  logic [7:0] write_data,
  input  logic       sda_in,
  output res_t       res
);

  phase_t      phase;
  logic [3:0]  bit_index;
  logic [7:0]  shift_byte;
  logic [7:0]  held_data;
  logic        held_op;
  logic [1:0]  byte_index;
  logic [15:0] read_accum;
  logic [7:0]  tick_count;
  logic [1:0]  nack_flags;

  phase_t      phase_next;
  logic [3:0]  bit_index_next;
  logic [7:0]  shift_byte_next;
  logic [7:0]  held_data_next;
  logic        held_op_next;
  logic [1:0]  byte_index_next;
  logic [15:0] read_accum_next;
  logic [7:0]  tick_count_next;
  logic [1:0]  nack_flags_next;

  phase_t      ph;
  logic [3:0]  bx;
  logic [3:0]  bx_inc;
  logic [7:0]  sb;
  logic [1:0]  bi;
  logic [15:0] ra;
  logic [7:0]  tc;
  logic [1:0]  nf;
  logic        active;
  logic        bit_lvl;
  logic        ackbit;
  logic [8:0]  ticks;
  logic        last;

  always_comb begin
    ph              = phase;
    bx              = bit_index;
    sb              = shift_byte;
    bi              = byte_index;
    ra              = read_accum;
    tc              = tick_count;
    nf              = nack_flags;
    held_op_next    = held_op;
    held_data_next  = held_data;

    case (phase)
      PH_START_A, PH_START_B, PH_WB_LO, PH_WB_HI, PH_WA_LO, PH_WA_HI,
      PH_RB_LO, PH_RB_HI, PH_MA_LO, PH_MA_HI, PH_STOP_A, PH_STOP_B,
      PH_STOP_C: active = 1'b1;
      default:   active = 1'b0;
    endcase

    if (!active) begin
      ph = PH_IDLE;
      if (cmd_valid) begin
        held_op_next   = opcode;
        held_data_next = write_data;
        sb             = {slave_addr, opcode};
        bi             = BYTE_ADDR;
        bx             = 4'd0;
        ra             = 16'd0;
        nf             = 2'd0;
        tc             = 8'd0;
        ph             = PH_START_A;
      end
    end

    bit_lvl = sb[7];
    ackbit  = (bi == BYTE_FIRST) ? 1'b0 : 1'b1;
    bx_inc  = bx + 4'd1;
    ticks   = (phase_ticks == 8'd0) ? 9'd1 : {1'b0, phase_ticks};
    last    = ({1'b0, tc} + 9'd1) >= ticks;

    phase_next      = ph;
    bit_index_next  = bx;
    shift_byte_next = sb;
    byte_index_next = bi;
    read_accum_next = ra;
    tick_count_next = tc;
    nack_flags_next = nf;

    res           = '0;
    res.scl       = 1'b1;
    res.sda_out   = 1'b1;
    res.sda_drive = 1'b1;

    if (ph != PH_IDLE) begin
      res.busy_res = 1'b1;
      case (ph)
        PH_START_A: begin res.scl = 1'b1; res.sda_out = 1'b1;    res.sda_drive = 1'b1; end
        PH_START_B: begin res.scl = 1'b1; res.sda_out = 1'b0;    res.sda_drive = 1'b1; end
        PH_WB_LO:   begin res.scl = 1'b0; res.sda_out = bit_lvl; res.sda_drive = 1'b1; end
        PH_WB_HI:   begin res.scl = 1'b1; res.sda_out = bit_lvl; res.sda_drive = 1'b1; end
        PH_WA_LO, PH_RB_LO: begin
          res.scl = 1'b0; res.sda_out = 1'b1; res.sda_drive = 1'b0;
        end
        PH_WA_HI, PH_RB_HI: begin
          res.scl = 1'b1; res.sda_out = 1'b1; res.sda_drive = 1'b0;
        end
        PH_MA_LO:   begin res.scl = 1'b0; res.sda_out = ackbit;  res.sda_drive = 1'b1; end
        PH_MA_HI:   begin res.scl = 1'b1; res.sda_out = ackbit;  res.sda_drive = 1'b1; end
        PH_STOP_A:  begin res.scl = 1'b0; res.sda_out = 1'b0;    res.sda_drive = 1'b1; end
        PH_STOP_B:  begin res.scl = 1'b1; res.sda_out = 1'b0;    res.sda_drive = 1'b1; end
        default:    begin res.scl = 1'b1; res.sda_out = 1'b1;    res.sda_drive = 1'b1; end
      endcase

      if (!last) begin
        tick_count_next = tc + 8'd1;
      end else begin
        tick_count_next = 8'd0;
        case (ph)
          PH_START_A: phase_next = PH_START_B;
          PH_START_B: begin
            bit_index_next = 4'd0;
            phase_next     = PH_WB_LO;
          end
          PH_WB_LO: phase_next = PH_WB_HI;
          PH_WB_HI: begin
            shift_byte_next = {sb[6:0], 1'b0};
            bit_index_next  = bx_inc;
            phase_next      = (bx_inc >= BITS_PER_BYTE) ? PH_WA_LO : PH_WB_LO;
          end
          PH_WA_LO: phase_next = PH_WA_HI;
          PH_WA_HI: begin
            if (bi == BYTE_ADDR) begin
              nack_flags_next = nf | {1'b0, sda_in};
              byte_index_next = BYTE_FIRST;
              bit_index_next  = 4'd0;
              if (held_op_next == OP_READ) begin
                phase_next = PH_RB_LO;
              end else begin
                shift_byte_next = held_data_next;
                phase_next      = PH_WB_LO;
              end
            end else begin
              nack_flags_next = nf | {sda_in, 1'b0};
              phase_next      = PH_STOP_A;
            end
          end
          PH_RB_LO: phase_next = PH_RB_HI;
          PH_RB_HI: begin
            read_accum_next = {ra[14:0], sda_in};
            bit_index_next  = bx_inc;
            phase_next      = (bx_inc >= BITS_PER_BYTE) ? PH_MA_LO : PH_RB_LO;
          end
          PH_MA_LO: phase_next = PH_MA_HI;
          PH_MA_HI: begin
            if (bi == BYTE_FIRST) begin
              byte_index_next = BYTE_SECOND;
              bit_index_next  = 4'd0;
              phase_next      = PH_RB_LO;
            end else begin
              phase_next = PH_STOP_A;
            end
          end
          PH_STOP_A: phase_next = PH_STOP_B;
          PH_STOP_B: phase_next = PH_STOP_C;
          default: begin
            phase_next    = PH_IDLE;
            res.done_res  = 1'b1;
            res.addr_nack = nf[0];
            if (held_op_next == OP_READ) begin
              res.read_word = ra;
            end else begin
              res.data_nack = nf[1];
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      bit_index  <= 4'd0;
      shift_byte <= 8'd0;
      held_data  <= 8'd0;
      held_op    <= 1'b0;
      byte_index <= BYTE_ADDR;
      read_accum <= 16'd0;
      tick_count <= 8'd0;
      nack_flags <= 2'd0;
    end else if (step) begin
      phase      <= phase_next;
      bit_index  <= bit_index_next;
      shift_byte <= shift_byte_next;
      held_data  <= held_data_next;
      held_op    <= held_op_next;
      byte_index <= byte_index_next;
      read_accum <= read_accum_next;
      tick_count <= tick_count_next;
      nack_flags <= nack_flags_next;
    end
  end

endmodule

>>> hw/rtl/i2c_master_byte_transactions.sv
// ----------------------------------------------------------------------------
// I2C master byte transactions: top level
// Bus tick input channel, phase length register, registered result channel.
// ----------------------------------------------------------------------------
// Each input transaction is one bus tick and yields exactly one result in the
// next cycle, so the block takes one transaction per clock cycle; the only
// hold-off is out_stall on a full result register, which passes straight back
// to in_stall. A write of phase_ticks applies from the next accepted tick.
// The phase_ticks register sets the length of every bus phase of a transaction.
module i2c_master_byte_transactions
  import i2cmbt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        cmd_valid,
  input  logic        opcode,
  input  logic [6:0]  slave_addr,
  input  logic [7:0]  write_data,
  input  logic        sda_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        scl,
  output logic        sda_out,
  output logic        sda_drive,
  output logic        busy_res,
  output logic        done_res,
  output logic [15:0] read_word,
  output logic        addr_nack,
  output logic        data_nack
);

  logic [7:0] phase_ticks;
  logic       accept;
  res_t       res;
  res_t       res_q;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid & out_stall;
  assign accept    = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_ticks <= 8'd1;
    end else if (cfg_valid && cfg_ready) begin
      phase_ticks <= cfg_data;
    end
  end

  i2cmbt_core u_core (
    .clk         (clk),
    .rst         (rst),
    .step        (accept),
    .phase_ticks (phase_ticks),
    .cmd_valid   (cmd_valid),
    .opcode      (opcode),
    .slave_addr  (slave_addr),
    .write_data  (write_data),
    .sda_in      (sda_in),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_q <= res;
    end
  end

  assign scl       = res_q.scl;
  assign sda_out   = res_q.sda_out;
  assign sda_drive = res_q.sda_drive;
  assign busy_res  = res_q.busy_res;
  assign done_res  = res_q.done_res;
  assign read_word = res_q.read_word;
  assign addr_nack = res_q.addr_nack;
  assign data_nack = res_q.data_nack;

  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("result register not loaded after accept");

  a_idle_bus: assert property (@(posedge clk) disable iff (rst)
    out_valid && !busy_res |-> scl && sda_drive && sda_out && !done_res)
    else $error("idle tick does not hold the bus released high");

  a_release_high: assert property (@(posedge clk) disable iff (rst)
    out_valid && !sda_drive |-> sda_out && busy_res)
    else $error("released SDA reported low or outside a transaction");

  a_flags_on_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && (read_word != 16'd0 || addr_nack || data_nack) |-> done_res)
    else $error("read word or nack flag outside the done tick");

endmodule
